// File: rtl/pcft_pkg.sv
// ----------------------------------------------------------------------------
// pcft_pkg: shared types, constants and helpers for the prefix-code counter
// Holds the table entry type, field widths and the identifier check.
// ----------------------------------------------------------------------------
package pcft_pkg;

  localparam int unsigned TableDepthDefault = 128;
  localparam int unsigned TopKDefault       = 5;

  localparam int unsigned CodeW  = 24;
  localparam int unsigned TallyW = 32;
  localparam int unsigned CharsW = 32;
  localparam int unsigned RankW  = 3;

  localparam logic [7:0] ChUpperLo = 8'h41;  // 'A'
  localparam logic [7:0] ChUpperHi = 8'h5A;  // 'Z'
  localparam logic [7:0] ChDigitLo = 8'h30;  // '0'
  localparam logic [7:0] ChDigitHi = 8'h39;  // '9'

  localparam logic OpRecord = 1'b0;
  localparam logic OpReport = 1'b1;

  typedef struct packed {
    logic [CodeW-1:0]  code;
    logic [TallyW-1:0] tally;
  } entry_t;

  typedef struct packed {
    logic   shift;
    logic   wr;
    entry_t wr_data;
  } cell_ctl_t;

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= ChUpperLo) && (c <= ChUpperHi);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= ChDigitLo) && (c <= ChDigitHi);
  endfunction

  // Three uppercase letters followed by a digit
  function automatic logic ident_ok(input logic [CharsW-1:0] ch);
    return is_upper(ch[31:24]) && is_upper(ch[23:16]) && is_upper(ch[15:8])
        && is_digit(ch[7:0]);
  endfunction

  function automatic logic [TallyW-1:0] sat_inc(input logic [TallyW-1:0] t);
    return (&t) ? t : t + TallyW'(1);
  endfunction

endpackage

// File: rtl/pcft_if.sv
// ----------------------------------------------------------------------------
// pcft_in_if / pcft_out_if: valid-ready channels of the prefix-code counter
// One word moves when valid and ready are both high at a rising edge.
// ----------------------------------------------------------------------------
interface pcft_in_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [pcft_pkg::CharsW-1:0]   ident_chars;

  modport source (output valid, op, ident_chars, input ready);
  modport sink   (input valid, op, ident_chars, output ready);
endinterface

interface pcft_out_if;
  logic                          valid;
  logic                          ready;
  logic [pcft_pkg::RankW-1:0]    rank;
  logic [pcft_pkg::CodeW-1:0]    code;
  logic [pcft_pkg::TallyW-1:0]   tally;
  logic                          last;

  modport source (output valid, rank, code, tally, last, input ready);
  modport sink   (input valid, rank, code, tally, last, output ready);
endinterface

// File: rtl/pcft_cell.sv
// ----------------------------------------------------------------------------
// pcft_cell: one table slot of the rotating entry ring
// Takes its neighbor's entry on a shift, or a direct write from control.
// ----------------------------------------------------------------------------
module pcft_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pcft_pkg::cell_ctl_t ctl_i,
  input  pcft_pkg::entry_t    next_i,
  output pcft_pkg::entry_t    entry_o
);

  pcft_pkg::entry_t entry_q;
  pcft_pkg::entry_t entry_d;

  // Select direct write over shift, else hold
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.wr) begin
      entry_d = ctl_i.wr_data;
    end else if (ctl_i.shift) begin
      entry_d = next_i;
    end
  end

  // Hold the entry, clear it at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

// File: rtl/prefix_code_frequency_top_k_unit.sv
// ----------------------------------------------------------------------------
// prefix_code_frequency_top_k_unit: code frequency table with top-K report
// The table is a ring of TABLE_DEPTH cells that rotates one slot per cycle,
// during record and scan turns, past a single compare point at cell 0. A
// record word with a valid identifier takes one full turn of the ring, then
// an append step; a word with a bad identifier is dropped. Input ready is
// high only in idle. A report takes one full turn per sorted position, then a
// swap step and the output handshake; an empty table accepts a report and
// gives no result word.
// ----------------------------------------------------------------------------
module prefix_code_frequency_top_k_unit #(
  parameter int unsigned TABLE_DEPTH = pcft_pkg::TableDepthDefault,
  parameter int unsigned TOP_K       = pcft_pkg::TopKDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  pcft_in_if.sink           in_i,
  pcft_out_if.source        out_o
);

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(TABLE_DEPTH);
  localparam logic [CntW-1:0] TopKC  = (TOP_K < TABLE_DEPTH) ? CntW'(TOP_K) : DepthC;
  localparam logic [IdxW-1:0] LastPos = IdxW'(TABLE_DEPTH - 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_REC     = 3'd1;
  localparam logic [2:0] S_REC_END = 3'd2;
  localparam logic [2:0] S_SCAN    = 3'd3;
  localparam logic [2:0] S_SWAP    = 3'd4;
  localparam logic [2:0] S_OUT     = 3'd5;

  logic [2:0]                    state_q, state_d;
  logic [IdxW-1:0]               pos_q, pos_d;
  logic [CntW-1:0]               used_q, used_d;
  logic [CntW-1:0]               sel_q, sel_d;
  logic [CntW-1:0]               num_q, num_d;
  logic                          hit_q, hit_d;
  logic [pcft_pkg::CodeW-1:0]    code_q, code_d;
  pcft_pkg::entry_t              best_q, best_d;
  pcft_pkg::entry_t              orig_q, orig_d;
  logic [IdxW-1:0]               best_pos_q, best_pos_d;
  logic                          out_valid_q, out_valid_d;
  logic [pcft_pkg::RankW-1:0]    out_rank_q, out_rank_d;
  pcft_pkg::entry_t              out_ent_q, out_ent_d;
  logic                          out_last_q, out_last_d;

  pcft_pkg::entry_t              ring [TABLE_DEPTH];
  pcft_pkg::entry_t              head;
  pcft_pkg::entry_t              wrap;
  logic                          in_range;
  logic                          match;
  logic                          shift;
  logic [CntW-1:0]               pos_ext;

  assign head    = ring[0];
  assign pos_ext = CntW'(pos_q);
  assign in_range = pos_ext < used_q;
  assign match   = (state_q == S_REC) && in_range && (head.code == code_q);
  assign shift   = (state_q == S_REC) || (state_q == S_SCAN);

  // Bump the head tally as it wraps around on a hit
  always_comb begin
    wrap = head;
    if (match) begin
      wrap.tally = pcft_pkg::sat_inc(head.tally);
    end
  end

  // Build the ring of cells
  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    localparam logic [CntW-1:0] KC = CntW'(k);
    localparam logic [IdxW-1:0] KI = IdxW'(k);
    pcft_pkg::cell_ctl_t ctl;
    pcft_pkg::entry_t    nxt;

    if (k == TABLE_DEPTH - 1) begin : g_wrap
      assign nxt = wrap;
    end else begin : g_mid
      assign nxt = ring[k+1];
    end

    always_comb begin
      ctl.shift   = shift;
      ctl.wr      = 1'b0;
      ctl.wr_data = best_q;
      if (state_q == S_SWAP) begin
        if (sel_q == KC) begin
          ctl.wr      = 1'b1;
          ctl.wr_data = best_q;
        end else if (best_pos_q == KI) begin
          ctl.wr      = 1'b1;
          ctl.wr_data = orig_q;
        end
      end else if (state_q == S_REC_END) begin
        if (!hit_q && (used_q < DepthC) && (used_q == KC)) begin
          ctl.wr      = 1'b1;
          ctl.wr_data = '{code: code_q, tally: pcft_pkg::TallyW'(1)};
        end
      end
    end

    pcft_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .next_i  (nxt),
      .entry_o (ring[k])
    );
  end

  assign in_i.ready = (state_q == S_IDLE);

  // Sequence record turns, sort turns and result words
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    used_d      = used_q;
    sel_d       = sel_q;
    num_d       = num_q;
    hit_d       = hit_q;
    code_d      = code_q;
    best_d      = best_q;
    orig_d      = orig_q;
    best_pos_d  = best_pos_q;
    out_valid_d = out_valid_q;
    out_rank_d  = out_rank_q;
    out_ent_d   = out_ent_q;
    out_last_d  = out_last_q;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          pos_d = '0;
          if (in_i.op == pcft_pkg::OpRecord) begin
            if (pcft_pkg::ident_ok(in_i.ident_chars)) begin
              code_d  = in_i.ident_chars[31:8];
              hit_d   = 1'b0;
              state_d = S_REC;
            end
          end else if (used_q != '0) begin
            num_d   = (used_q < TopKC) ? used_q : TopKC;
            sel_d   = '0;
            state_d = S_SCAN;
          end
        end
      end
      S_REC: begin
        hit_d = hit_q | match;
        pos_d = pos_q + IdxW'(1);
        if (pos_q == LastPos) begin
          state_d = S_REC_END;
        end
      end
      S_REC_END: begin
        if (!hit_q && (used_q < DepthC)) begin
          used_d = used_q + CntW'(1);
        end
        state_d = S_IDLE;
      end
      S_SCAN: begin
        if (pos_ext == sel_q) begin
          best_d     = head;
          orig_d     = head;
          best_pos_d = pos_q;
        end else if ((pos_ext > sel_q) && in_range && (head.tally > best_q.tally)) begin
          best_d     = head;
          best_pos_d = pos_q;
        end
        pos_d = pos_q + IdxW'(1);
        if (pos_q == LastPos) begin
          state_d = S_SWAP;
        end
      end
      S_SWAP: begin
        out_valid_d = 1'b1;
        out_rank_d  = sel_q[pcft_pkg::RankW-1:0];
        out_ent_d   = best_q;
        out_last_d  = (sel_q + CntW'(1)) == num_q;
        state_d     = S_OUT;
      end
      S_OUT: begin
        if (out_o.ready) begin
          out_valid_d = 1'b0;
          pos_d       = '0;
          sel_d       = sel_q + CntW'(1);
          state_d     = out_last_q ? S_IDLE : S_SCAN;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      used_q      <= '0;
      sel_q       <= '0;
      num_q       <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      used_q      <= used_d;
      sel_q       <= sel_d;
      num_q       <= num_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    code_q     <= code_d;
    best_q     <= best_d;
    orig_q     <= orig_d;
    best_pos_q <= best_pos_d;
    out_rank_q <= out_rank_d;
    out_ent_q  <= out_ent_d;
    out_last_q <= out_last_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.rank  = out_rank_q;
  assign out_o.code  = out_ent_q.code;
  assign out_o.tally = out_ent_q.tally;
  assign out_o.last  = out_last_q;

endmodule
